// ===== design/priority_sorted_job_list_core_assert.svh =====
// assertion macros used by the job list core rtl
// plain property checks in simulation, empty in synthesis
`ifndef PRIORITY_SORTED_JOB_LIST_CORE_ASSERT_SVH
`define PRIORITY_SORTED_JOB_LIST_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define PSJL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PSJL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PSJL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define PSJL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== design/psjl_pkg.sv =====
// shared types, codes and defaults for the sorted job list
// no dependencies
`default_nettype none

package psjl_pkg;

    localparam int DEPTH_DEFAULT = 32;

    localparam logic [1:0] MODE_INSERT   = 2'd0;
    localparam logic [1:0] MODE_DUMP     = 2'd1;
    localparam logic [1:0] MODE_CLEAR    = 2'd2;
    localparam logic [1:0] MODE_RESERVED = 2'd3;

    localparam logic [2:0] STATUS_INSERTED   = 3'd0;
    localparam logic [2:0] STATUS_DUPLICATE  = 3'd1;
    localparam logic [2:0] STATUS_FULL       = 3'd2;
    localparam logic [2:0] STATUS_DUMP_ENTRY = 3'd3;
    localparam logic [2:0] STATUS_DUMP_EMPTY = 3'd4;
    localparam logic [2:0] STATUS_CLEARED    = 3'd5;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  job_type;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
    } job_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  out_type;
        logic [15:0] out_x;
        logic [15:0] out_y;
        logic        last;
    } res_t;

    typedef struct packed {
        logic [7:0]  job_type;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_SHIFT,
        ST_PLACE,
        ST_DUMP_RD,
        ST_DUMP_LD,
        ST_RESP
    } state_t;

endpackage

`default_nettype wire

// ===== design/psjl_mem.sv =====
// entry store of the job list: one write port, one registered read port
// depends on psjl_pkg
`default_nettype none

module psjl_mem #(
    parameter int DEPTH = psjl_pkg::DEPTH_DEFAULT,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output psjl_pkg::entry_t      rd_data,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire psjl_pkg::entry_t wr_data
);

    psjl_pkg::entry_t mem_reg [DEPTH];
    psjl_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== design/priority_sorted_job_list_core.sv =====
// Sorted job list, ascending by job type, up to DEPTH entries.
// Input channel job (job_valid/job_ready) carries mode, type and position;
// output channel res (res_valid/res_ready) carries status, entry and last.
// A beat is taken on each edge where valid and ready are both high.
// Insert: one scan pass over the stored entries through the single memory
// read port, then a tail-to-position shift of one entry a cycle plus
// placement, then one result. Duplicate or full inserts skip the shift.
// Dump: one result per entry, each a memory read, then a load of the
// output register; an empty list gives one beat with status dump empty.
// Clear gives one result with status cleared; mode 3 is ignored.
// job_ready is high only while the sequencer is idle; one item is in work.
// Results sit in an output register, so a new item is taken while the last
// result still waits; a stalled receiver holds the sequencer only when it
// has another result to hand over.
// Reset empties the list at once (count to zero); the store is not swept.
`default_nettype none
`include "priority_sorted_job_list_core_assert.svh"

module priority_sorted_job_list_core #(
    parameter int DEPTH = psjl_pkg::DEPTH_DEFAULT
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           job_valid,
    output logic                job_ready,
    input  wire psjl_pkg::job_t job,
    output logic                res_valid,
    input  wire logic           res_ready,
    output psjl_pkg::res_t      res
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    psjl_pkg::state_t state_reg, state_next;

    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [CW-1:0]    pos_reg, pos_next;
    logic [CW-1:0]    sh_reg, sh_next;
    logic             found_reg, found_next;
    logic             dup_reg, dup_next;
    logic             wb_vld_reg, wb_vld_next;
    logic [AW-1:0]    wb_addr_reg, wb_addr_next;
    logic [2:0]       stat_reg, stat_next;
    psjl_pkg::job_t   job_reg, job_next;
    logic             res_vld_reg;
    psjl_pkg::res_t   res_reg;

    logic             accept;
    logic             out_free;
    logic [CW-1:0]    idx_inc;
    logic [CW-1:0]    idx_dec;
    logic [CW-1:0]    sh_dec;
    logic             dump_last;
    logic             is_match;
    logic             is_ge;

    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    psjl_pkg::entry_t rd_data;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    psjl_pkg::entry_t wr_data;
    logic             res_load;
    psjl_pkg::res_t   res_data;

    assign accept    = job_valid && job_ready;
    assign job_ready = (state_reg == psjl_pkg::ST_IDLE);
    assign out_free  = !res_vld_reg || res_ready;
    assign idx_inc   = idx_reg + CW'(1);
    assign idx_dec   = idx_reg - CW'(1);
    assign sh_dec    = sh_reg - CW'(1);
    assign dump_last = (idx_inc == cnt_reg);
    assign is_match  = (rd_data.job_type == job_reg.job_type) &&
                       (rd_data.pos_x == job_reg.pos_x) &&
                       (rd_data.pos_y == job_reg.pos_y);
    assign is_ge     = (rd_data.job_type >= job_reg.job_type);

    psjl_mem #(
        .DEPTH(DEPTH)
    ) u_mem (
        .clk    (clk),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            psjl_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (job.mode)
                        psjl_pkg::MODE_INSERT: state_next = psjl_pkg::ST_SCAN;
                        psjl_pkg::MODE_DUMP:
                        begin
                            state_next = (cnt_reg == '0) ? psjl_pkg::ST_RESP
                                                         : psjl_pkg::ST_DUMP_RD;
                        end
                        psjl_pkg::MODE_CLEAR:  state_next = psjl_pkg::ST_RESP;
                        default:               state_next = psjl_pkg::ST_IDLE;
                    endcase
                end
            end
            psjl_pkg::ST_SCAN:
            begin
                if (idx_reg == cnt_reg)
                begin
                    state_next = psjl_pkg::ST_DECIDE;
                end
            end
            psjl_pkg::ST_DECIDE:
            begin
                state_next = (dup_reg || cnt_reg == FULL_COUNT) ? psjl_pkg::ST_RESP
                                                                : psjl_pkg::ST_SHIFT;
            end
            psjl_pkg::ST_SHIFT:
            begin
                if (sh_reg == pos_reg)
                begin
                    state_next = psjl_pkg::ST_PLACE;
                end
            end
            psjl_pkg::ST_PLACE:   state_next = psjl_pkg::ST_RESP;
            psjl_pkg::ST_DUMP_RD:
            begin
                if (out_free)
                begin
                    state_next = psjl_pkg::ST_DUMP_LD;
                end
            end
            psjl_pkg::ST_DUMP_LD:
            begin
                state_next = dump_last ? psjl_pkg::ST_IDLE : psjl_pkg::ST_DUMP_RD;
            end
            psjl_pkg::ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = psjl_pkg::ST_IDLE;
                end
            end
            default: state_next = psjl_pkg::ST_IDLE;
        endcase
    end

    // memory and output register controls
    always_comb
    begin
        rd_en    = 1'b0;
        rd_addr  = idx_reg[AW-1:0];
        wr_en    = 1'b0;
        wr_addr  = wb_addr_reg;
        wr_data  = rd_data;
        res_load = 1'b0;
        res_data = '{status: stat_reg, out_type: 8'd0, out_x: 16'd0,
                     out_y: 16'd0, last: 1'b1};
        unique case (state_reg)
            psjl_pkg::ST_SCAN:
            begin
                rd_en = (idx_reg != cnt_reg);
            end
            psjl_pkg::ST_SHIFT:
            begin
                wr_en   = wb_vld_reg;
                rd_en   = (sh_reg != pos_reg);
                rd_addr = sh_dec[AW-1:0];
            end
            psjl_pkg::ST_PLACE:
            begin
                wr_en   = 1'b1;
                wr_addr = pos_reg[AW-1:0];
                wr_data = '{job_type: job_reg.job_type, pos_x: job_reg.pos_x,
                            pos_y: job_reg.pos_y};
            end
            psjl_pkg::ST_DUMP_RD:
            begin
                rd_en = out_free;
            end
            psjl_pkg::ST_DUMP_LD:
            begin
                res_load = 1'b1;
                res_data = '{status: psjl_pkg::STATUS_DUMP_ENTRY,
                             out_type: rd_data.job_type, out_x: rd_data.pos_x,
                             out_y: rd_data.pos_y, last: dump_last};
            end
            psjl_pkg::ST_RESP:
            begin
                res_load = out_free;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        pos_next     = pos_reg;
        sh_next      = sh_reg;
        found_next   = found_reg;
        dup_next     = dup_reg;
        wb_vld_next  = wb_vld_reg;
        wb_addr_next = wb_addr_reg;
        stat_next    = stat_reg;
        job_next     = job_reg;
        case (state_reg)
            psjl_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    job_next   = job;
                    idx_next   = '0;
                    found_next = 1'b0;
                    dup_next   = 1'b0;
                    pos_next   = cnt_reg;
                    if (job.mode == psjl_pkg::MODE_CLEAR)
                    begin
                        cnt_next  = '0;
                        stat_next = psjl_pkg::STATUS_CLEARED;
                    end
                    else
                    begin
                        stat_next = psjl_pkg::STATUS_DUMP_EMPTY;
                    end
                end
            end
            psjl_pkg::ST_SCAN:
            begin
                if (idx_reg != '0)
                begin
                    if (is_match)
                    begin
                        dup_next = 1'b1;
                    end
                    if (!found_reg && is_ge)
                    begin
                        found_next = 1'b1;
                        pos_next   = idx_dec;
                    end
                end
                if (idx_reg != cnt_reg)
                begin
                    idx_next = idx_inc;
                end
            end
            psjl_pkg::ST_DECIDE:
            begin
                sh_next     = cnt_reg;
                wb_vld_next = 1'b0;
                if (dup_reg)
                begin
                    stat_next = psjl_pkg::STATUS_DUPLICATE;
                end
                else if (cnt_reg == FULL_COUNT)
                begin
                    stat_next = psjl_pkg::STATUS_FULL;
                end
                else
                begin
                    stat_next = psjl_pkg::STATUS_INSERTED;
                end
            end
            psjl_pkg::ST_SHIFT:
            begin
                if (sh_reg != pos_reg)
                begin
                    wb_vld_next  = 1'b1;
                    wb_addr_next = sh_reg[AW-1:0];
                    sh_next      = sh_dec;
                end
                else
                begin
                    wb_vld_next = 1'b0;
                end
            end
            psjl_pkg::ST_PLACE:
            begin
                cnt_next = cnt_reg + CW'(1);
            end
            psjl_pkg::ST_DUMP_LD:
            begin
                idx_next = idx_inc;
            end
            default:
            begin
                stat_next = stat_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= psjl_pkg::ST_IDLE;
            cnt_reg     <= '0;
            wb_vld_reg  <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            wb_vld_reg <= wb_vld_next;
            if (res_load)
            begin
                res_vld_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        pos_reg     <= pos_next;
        sh_reg      <= sh_next;
        found_reg   <= found_next;
        dup_reg     <= dup_next;
        wb_addr_reg <= wb_addr_next;
        stat_reg    <= stat_next;
        job_reg     <= job_next;
        if (res_load)
        begin
            res_reg <= res_data;
        end
    end

    assign res_valid = res_vld_reg;
    assign res       = res_reg;

    `PSJL_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= FULL_COUNT,
        "entry count above depth")
    `PSJL_ASSERT_IMP(a_load_free, clk, rst_n, res_load, out_free,
        "result loaded over a beat not yet taken")
    `PSJL_ASSERT_IMP(a_place_room, clk, rst_n, state_reg == psjl_pkg::ST_PLACE,
        cnt_reg < FULL_COUNT, "placement into a full list")
    `PSJL_ASSERT_IMP(a_wr_states, clk, rst_n, wr_en,
        state_reg == psjl_pkg::ST_SHIFT || state_reg == psjl_pkg::ST_PLACE,
        "store written outside an insert")
    `PSJL_ASSERT_NXT(a_clear, clk, rst_n, accept && job.mode == psjl_pkg::MODE_CLEAR,
        cnt_reg == '0, "clear did not empty the list")

endmodule

`default_nettype wire
